### src/mbd_pkg.sv
package mbd_pkg;

  // button slots in hardware and the usable limit
  localparam int NUM_BUTTONS = 8;
  localparam int SLOT_LIMIT  = 8;
  localparam int ACTIVE_MAX  = (NUM_BUTTONS < SLOT_LIMIT) ? NUM_BUTTONS : SLOT_LIMIT;

  localparam int TIME_W  = 32;
  localparam int SAMPLE_W = 32;
  localparam int PIN_W   = 5;
  localparam int IDX_W   = 3;
  localparam int COUNT_W = 4;
  localparam int MS_W    = 16;
  localparam int MAP_W   = 40;
  localparam int CFG_W   = 40;
  localparam int CFG_IDX_W = 3;

  localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [MS_W-1:0] LONG_RST     = 16'd600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 3'd0,
    CFG_LONG_PRESS = 3'd1,
    CFG_COUNT      = 3'd2,
    CFG_PIN_MAP    = 3'd3,
    CFG_LONG_EN    = 3'd4
  } cfg_reg_t;

  localparam logic EV_SHORT = 1'b0;
  localparam logic EV_LONG  = 1'b1;

  typedef struct packed {
    logic              pressed;
    logic [TIME_W-1:0] changed_at;
    logic              long_done;
  } btn_state_t;

  typedef struct packed {
    btn_state_t nxt;
    logic       fire;
    logic       kind;
  } step_res_t;

endpackage

### src/mbd_in_if.sv
interface mbd_in_if;
  logic                          valid;
  logic                          ready;
  logic [mbd_pkg::SAMPLE_W-1:0]  sample_bits;
  logic [mbd_pkg::TIME_W-1:0]    now_ms;

  modport source (output valid, sample_bits, now_ms, input ready);
  modport sink   (input valid, sample_bits, now_ms, output ready);
endinterface

### src/mbd_out_if.sv
interface mbd_out_if;
  logic                       valid;
  logic                       ready;
  logic [mbd_pkg::IDX_W-1:0]  button_index;
  logic                       event_kind;
  logic                       last;

  modport source (output valid, button_index, event_kind, last, input ready);
  modport sink   (input valid, button_index, event_kind, last, output ready);
endinterface

### src/mbd_step.sv
module mbd_step (
  input  logic                          pin_level,
  input  logic [mbd_pkg::TIME_W-1:0]    now_ms,
  input  logic                          has_long,
  input  logic [mbd_pkg::MS_W-1:0]      debounce_ms,
  input  logic [mbd_pkg::MS_W-1:0]      long_press_ms,
  input  mbd_pkg::btn_state_t           cur,
  output mbd_pkg::step_res_t            res
);
  import mbd_pkg::*;

  logic              pressed;
  logic [TIME_W-1:0] elapsed;
  logic              deb_ok;
  logic              hold_ok;

  // shared subtract and compares, one button per cycle
  assign pressed = ~pin_level;
  assign elapsed = now_ms - cur.changed_at;
  assign deb_ok  = elapsed >= {{(TIME_W-MS_W){1'b0}}, debounce_ms};
  assign hold_ok = elapsed >= {{(TIME_W-MS_W){1'b0}}, long_press_ms};

  always_comb begin
    res.nxt  = cur;
    res.fire = 1'b0;
    res.kind = EV_SHORT;
    if (pressed != cur.pressed) begin
      if (deb_ok) begin
        res.nxt.pressed    = pressed;
        res.nxt.changed_at = now_ms;
        if (pressed) begin
          res.nxt.long_done = 1'b0;
          res.fire          = ~has_long;
        end else begin
          res.fire = has_long & ~cur.long_done;
        end
      end
    end else if (pressed && has_long && !cur.long_done && hold_ok) begin
      res.nxt.long_done = 1'b1;
      res.fire          = 1'b1;
      res.kind          = EV_LONG;
    end
  end
endmodule

### src/multi_button_debounce_long_press.sv
// channel   dir   payload                               handshake
// in_if     in    sample_bits[31:0], now_ms[31:0]       valid/ready
// out_if    out   button_index[2:0], event_kind, last   valid/ready
// cfg       in    cfg_index[2:0], cfg_wdata[39:0]       cfg_we, no wait
//
// one sample is accepted, then each button in use passes in turn through the
// shared elapsed-time subtract/compare unit, then each event goes out as a beat
// (n buttons in use, n <= 8)
// glitch samples and samples with no buttons in use are dropped at accept
// reset is synchronous active low; button state and config registers reset together
// a stalled output holds the event phase; in_if.ready is high only when idle
module multi_button_debounce_long_press (
  input  logic                           clk,
  input  logic                           rst_n,
  mbd_in_if.sink                         in_if,
  mbd_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbd_pkg::CFG_W-1:0]      cfg_wdata
);
  import mbd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  // configuration registers
  logic [MS_W-1:0]       debounce_r;
  logic [MS_W-1:0]       long_press_r;
  logic [COUNT_W-1:0]    count_r;
  logic [MAP_W-1:0]      pin_map_r;
  logic [SLOT_LIMIT-1:0] long_en_r;

  // per-button state
  btn_state_t btn_r [SLOT_LIMIT];

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      idx_r;
  logic [SAMPLE_W-1:0]   bits_r;
  logic [TIME_W-1:0]     now_r;
  logic [SLOT_LIMIT-1:0] pend_r;       // buttons with an event this sample
  logic [SLOT_LIMIT-1:0] kind_r;

  logic                  out_valid_r;
  logic [IDX_W-1:0]      out_idx_r;
  logic                  out_kind_r;
  logic                  out_last_r;

  logic [COUNT_W-1:0]    active_n;
  logic [SAMPLE_W-1:0]   used_mask;
  logic                  in_beat;
  logic                  drop;
  logic [PIN_W-1:0]      cur_pin;
  step_res_t             step_res;
  logic                  scan_end;
  logic [IDX_W-1:0]      low_idx;
  logic [SLOT_LIMIT-1:0] pend_rest;
  logic                  out_load;

  // clamp the count to the slot limit
  assign active_n = (count_r > COUNT_W'(ACTIVE_MAX)) ? COUNT_W'(ACTIVE_MAX) : count_r;

  // pins of the buttons in use
  always_comb begin
    used_mask = '0;
    for (int i = 0; i < SLOT_LIMIT; i++) begin
      if (COUNT_W'(i) < active_n) begin
        used_mask = used_mask | (SAMPLE_W'(1) << pin_map_r[PIN_W*i +: PIN_W]);
      end
    end
  end

  assign in_if.ready = (state_r == S_IDLE);
  assign in_beat     = in_if.valid & in_if.ready;
  // nothing in use, or every used pin low: a bus glitch
  assign drop        = (active_n == '0) || ((in_if.sample_bits & used_mask) == '0);

  assign cur_pin  = pin_map_r[PIN_W*idx_r +: PIN_W];
  assign scan_end = ({1'b0, idx_r} == (active_n - COUNT_W'(1)));

  mbd_step u_step (
    .pin_level     (bits_r[cur_pin]),
    .now_ms        (now_r),
    .has_long      (long_en_r[idx_r]),
    .debounce_ms   (debounce_r),
    .long_press_ms (long_press_r),
    .cur           (btn_r[idx_r]),
    .res           (step_res)
  );

  // lowest pending button goes out first
  always_comb begin
    low_idx = '0;
    for (int i = SLOT_LIMIT - 1; i >= 0; i--) begin
      if (pend_r[i]) low_idx = IDX_W'(i);
    end
  end
  assign pend_rest = pend_r & (pend_r - SLOT_LIMIT'(1));
  assign out_load  = (state_r == S_EMIT) && (pend_r != '0) && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_beat && !drop) state_nxt = S_SCAN;
      S_SCAN: if (scan_end) state_nxt = S_EMIT;
      S_EMIT: if (pend_r == '0) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_RST;
      count_r      <= '0;
      pin_map_r    <= '0;
      long_en_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[MS_W-1:0];
        CFG_LONG_PRESS: long_press_r <= cfg_wdata[MS_W-1:0];
        CFG_COUNT:      count_r      <= cfg_wdata[COUNT_W-1:0];
        CFG_PIN_MAP:    pin_map_r    <= cfg_wdata[MAP_W-1:0];
        CFG_LONG_EN:    long_en_r    <= cfg_wdata[SLOT_LIMIT-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and button state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      pend_r  <= '0;
      for (int i = 0; i < SLOT_LIMIT; i++) btn_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_beat) begin
        idx_r  <= '0;
        pend_r <= '0;
      end
      if (state_r == S_SCAN) begin
        btn_r[idx_r]  <= step_res.nxt;
        pend_r[idx_r] <= step_res.fire;
        idx_r         <= idx_r + IDX_W'(1);
      end
      if (out_load) pend_r <= pend_rest;
    end
  end

  // sample capture and kind bits
  always_ff @(posedge clk) begin
    if (in_beat) begin
      bits_r <= in_if.sample_bits;
      now_r  <= in_if.now_ms;
    end
    if (state_r == S_SCAN) kind_r[idx_r] <= step_res.kind;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= low_idx;
      out_kind_r <= kind_r[low_idx];
      out_last_r <= (pend_rest == '0);
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.button_index = out_idx_r;
  assign out_if.event_kind   = out_kind_r;
  assign out_if.last         = out_last_r;

  // scan never visits a button beyond the count in use
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ({1'b0, idx_r} < active_n))
    else $error("scan index beyond buttons in use");

  // a beat not marked last keeps the event phase going
  a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == S_EMIT) && (pend_r != '0))
    else $error("no events pending behind a beat not marked last");

  // dropped samples leave the state of button 0 untouched
  a_drop_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && drop) |=> (state_r == S_IDLE) && $stable(btn_r[0]))
    else $error("dropped sample changed state");

  // an event is loaded only when the output register is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> $stable(out_idx_r) && $stable(out_last_r))
    else $error("stalled event overwritten");

endmodule
